// ===== rtl/dtb_pkg.sv =====
// ----------------------------------------------------------------------------
// dtb_pkg
// Shared constants, status codes and the queue item type of the descriptor
// table builder.
// ----------------------------------------------------------------------------
package dtb_pkg;

	localparam int unsigned PAGE_BYTES      = 4096;
	localparam int unsigned MAX_ENTRIES_DEF = 64;
	localparam int unsigned OFF_W           = $clog2(PAGE_BYTES);
	localparam int unsigned CHUNK_W         = $clog2(PAGE_BYTES + 1);
	localparam int unsigned FIFO_DEPTH      = 2;

	localparam logic [1:0] ALIGN_MASK = 2'h3;

	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_REJ = 2'd1;
	localparam logic [1:0] ST_OVF = 2'd2;

	typedef struct packed {
		logic               reject;
		logic [31:0]        vaddr;
		logic [23:0]        count;
		logic [CHUNK_W-1:0] first_chunk;
	} dtb_item_t;

endpackage

// ===== rtl/dtb_front.sv =====
// ----------------------------------------------------------------------------
// dtb_front
// Accepts transfer requests, checks count and alignment and works out the
// size of the first descriptor, then hands the request to the queue.
// ----------------------------------------------------------------------------
module dtb_front
	import dtb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] buffer_address,
	input  logic [23:0] byte_count,
	output logic        push,
	output dtb_item_t   push_item,
	input  logic        q_full
);

	logic      valid_s1;
	dtb_item_t item_s1;

	assign in_stall  = valid_s1 && q_full;
	assign push      = valid_s1 && !q_full;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1.reject      <= (byte_count == 24'd0)
				|| ((buffer_address[1:0] & ALIGN_MASK) != 2'd0)
				|| ((byte_count[1:0] & ALIGN_MASK) != 2'd0);
			item_s1.vaddr       <= buffer_address;
			item_s1.count       <= byte_count;
			item_s1.first_chunk <= CHUNK_W'(PAGE_BYTES)
				- CHUNK_W'(buffer_address[OFF_W-1:0]);
		end
	end

endmodule

// ===== rtl/dtb_fifo.sv =====
// ----------------------------------------------------------------------------
// dtb_fifo
// Short queue of classified requests between the front and the back end.
// ----------------------------------------------------------------------------
module dtb_fifo
	import dtb_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  dtb_item_t push_item,
	output logic      full,
	input  logic      pop,
	output dtb_item_t pop_item,
	output logic      empty
);

	localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
	localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

	dtb_item_t        mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full     = (cnt_q == CNT_W'(FIFO_DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push || pop)
		else $error("queue written while full");
	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop)
		else $error("queue read while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(FIFO_DEPTH))
		else $error("queue count out of range");

endmodule

// ===== rtl/dtb_back.sv =====
// ----------------------------------------------------------------------------
// dtb_back
// Takes requests from the queue and, while out_stall is low, writes one
// descriptor per cycle to the output register, or one error word per reject.
// ----------------------------------------------------------------------------
module dtb_back
	import dtb_pkg::*;
#(
	parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [31:0] phys_offset,
	output logic        pop,
	input  dtb_item_t   pop_item,
	input  logic        q_empty,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] entry_base,
	output logic [12:0] entry_bytes,
	output logic        last,
	output logic [1:0]  status
);

	localparam int unsigned N_W = $clog2(MAX_ENTRIES);

	logic               busy_q;
	logic [31:0]        vaddr_q;
	logic [23:0]        count_q;
	logic [CHUNK_W-1:0] chunk_q;
	logic [N_W-1:0]     n_q;

	logic               out_valid_q;
	logic [31:0]        base_q;
	logic [12:0]        bytes_q;
	logic               last_q;
	logic [1:0]         status_q;

	logic               advance;
	logic [23:0]        chunk;
	logic [23:0]        rem;
	logic               done;
	logic               ovf;

	assign advance = !out_valid_q || !out_stall;
	assign pop     = !busy_q && advance && !q_empty;

	assign chunk = (24'(chunk_q) > count_q) ? count_q : 24'(chunk_q);
	assign rem   = count_q - chunk;
	assign done  = (rem == 24'd0);
	assign ovf   = (n_q == N_W'(MAX_ENTRIES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			if (busy_q) begin
				busy_q      <= !(done || ovf);
				out_valid_q <= 1'b1;
			end else if (pop) begin
				busy_q      <= !pop_item.reject;
				out_valid_q <= pop_item.reject;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (busy_q) begin
				base_q   <= vaddr_q - phys_offset;
				bytes_q  <= chunk[12:0];
				last_q   <= done || ovf;
				status_q <= done ? ST_OK : (ovf ? ST_OVF : ST_OK);
				vaddr_q  <= vaddr_q + 32'(chunk);
				count_q  <= rem;
				chunk_q  <= CHUNK_W'(PAGE_BYTES);
				n_q      <= n_q + 1'b1;
			end else if (pop) begin
				base_q   <= 32'd0;
				bytes_q  <= 13'd0;
				last_q   <= 1'b1;
				status_q <= ST_REJ;
				vaddr_q  <= pop_item.vaddr;
				count_q  <= pop_item.count;
				chunk_q  <= pop_item.first_chunk;
				n_q      <= '0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign entry_base  = base_q;
	assign entry_bytes = bytes_q;
	assign last        = last_q;
	assign status      = status_q;

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !busy_q)
		else $error("request taken while a run is in progress");
	a_run_open: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !last_q) |-> busy_q)
		else $error("run ended without a last descriptor");
	a_err_word: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (status_q != ST_OK)) |-> last_q)
		else $error("error status on a word that is not last");
	a_rej_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (status_q == ST_REJ)) |-> (bytes_q == 13'd0 && base_q == 32'd0))
		else $error("rejected request carries a nonzero descriptor");

endmodule

// ===== rtl/dma_descriptor_table_builder.sv =====
// ----------------------------------------------------------------------------
// dma_descriptor_table_builder
// Turns a transfer request into a run of page-bounded scatter-gather
// descriptors.
//
// The input channel (in_valid, in_stall) carries one request per word: a
// buffer virtual address and a byte count. The output channel (out_valid,
// out_stall) carries one descriptor per word: physical base, byte count,
// last flag and status. A request with a zero count or a misaligned address
// or count yields one error word. A request needing more than MAX_ENTRIES
// descriptors is cut at MAX_ENTRIES, the final one marked with overflow.
// A request's first descriptor passes the front register, the queue, the
// back end's working registers and the output register; an error word
// skips the working registers. The back end then writes one descriptor per
// cycle into the output register while the receiver does not stall, and
// takes no new request until the run ends. A two-entry queue lets new requests
// be accepted while a run is still being emitted. When the receiver stalls,
// the output word holds and the back end waits; the queue fills and in_stall
// rises. Reset clears all words in flight and sets phys_offset to zero.
// ----------------------------------------------------------------------------
module dma_descriptor_table_builder
	import dtb_pkg::*;
#(
	parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] buffer_address,
	input  logic [23:0] byte_count,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] entry_base,
	output logic [12:0] entry_bytes,
	output logic        last,
	output logic [1:0]  status
);

	logic [31:0] phys_offset_q;
	logic        push;
	logic        pop;
	logic        q_full;
	logic        q_empty;
	dtb_item_t   push_item;
	dtb_item_t   pop_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phys_offset_q <= 32'd0;
		end else if (cfg_we) begin
			phys_offset_q <= cfg_wdata;
		end
	end

	dtb_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.buffer_address (buffer_address),
		.byte_count     (byte_count),
		.push           (push),
		.push_item      (push_item),
		.q_full         (q_full)
	);

	dtb_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.pop_item  (pop_item),
		.empty     (q_empty)
	);

	dtb_back #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.phys_offset (phys_offset_q),
		.pop         (pop),
		.pop_item    (pop_item),
		.q_empty     (q_empty),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.entry_base  (entry_base),
		.entry_bytes (entry_bytes),
		.last        (last),
		.status      (status)
	);

endmodule
